FILE: rtl/tmt_pkg.sv
// Package for the tournament max tree: field widths, request and response codes,
// and the sequencer state type.
// No dependencies; every other file of the block imports it.
package tmt_pkg;

   // Fixed field widths of the request and response channels.
   localparam int REQ_TYPE_W = 2;
   localparam int PLAYER_W   = 8;
   localparam int SKILL_W    = 32;
   localparam int WINS_W     = 4;

   // Default tree depth: 2^8 players.
   localparam int DEFAULT_LOG_PLAYERS = 8;

   // Saturation value of the wins count.
   localparam logic [WINS_W-1:0] WINS_MAX = {WINS_W{1'b1}};

   // Request codes.
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_SET   = 2'd0,
      REQ_CHAMP = 2'd1,
      REQ_WINS  = 2'd2
   } req_code_type;

   // Response kinds.
   typedef enum logic {
      RSP_CHAMP = 1'b0,
      RSP_WINS  = 1'b1
   } rsp_kind_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SET,
      ST_CHAMP,
      ST_WLEAF,
      ST_WCMP
   } state_type;

endpackage

FILE: rtl/tmt_req_if.sv
// Request channel of the tournament max tree: valid/ready handshake and payload.
// Depends on tmt_pkg for the field widths.
interface tmt_req_if
   import tmt_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [PLAYER_W-1:0]   player;
   logic [SKILL_W-1:0]    skill;

   modport source (output valid, req_type, player, skill, input ready);
   modport sink   (input valid, req_type, player, skill, output ready);
endinterface

FILE: rtl/tmt_rsp_if.sv
// Response channel of the tournament max tree: valid/ready handshake and payload.
// Depends on tmt_pkg for the field widths.
interface tmt_rsp_if
   import tmt_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                resp_kind;
   logic [PLAYER_W-1:0] champion;
   logic [SKILL_W-1:0]  champion_skill;
   logic [WINS_W-1:0]   wins;

   modport source (output valid, resp_kind, champion, champion_skill, wins, input ready);
   modport sink   (input valid, resp_kind, champion, champion_skill, wins, output ready);
endinterface

FILE: rtl/tournament_max_tree.sv
// Tournament max tree: node memory, level-walking sequencer and response register.
// Depends on tmt_pkg, tmt_req_if and tmt_rsp_if.
//
//  Channel    Direction  Handshake     Carries
//  req_chan   in         valid/ready   req_type, player, skill
//  rsp_chan   out        valid/ready   resp_kind, champion, champion_skill, wins
//
// A set request writes one node per tree level, from the leaf up to the root, while it
// reads the sibling through the separate read port. A wins request reads the leaf, then
// one ancestor at a time up to a mismatch or the root; a champion query reads the root.
// The request side is ready only while the sequencer is idle. The response sits in
// an output register; a finished query waits there until the sink takes it.
// Reset is synchronous; the node memory is not cleared and is valid once written.
module tournament_max_tree
   import tmt_pkg::*;
#(
   parameter int LOG_PLAYERS = DEFAULT_LOG_PLAYERS
) (
   input  logic      clock,
   input  logic      reset,
   tmt_req_if.sink   req_chan,
   tmt_rsp_if.source rsp_chan
);

   localparam int ADDR_W = LOG_PLAYERS + 1;
   localparam int NODE_W = SKILL_W + LOG_PLAYERS;
   localparam int NODES  = 2 ** ADDR_W;
   localparam logic [ADDR_W-1:0] ROOT_ADDR = ADDR_W'(1);

   // Node memory: each entry is {skill, player}. Comparing entries as unsigned
   // numbers gives the match rule directly (skill first, player breaks ties).
   logic [NODE_W-1:0] node_mem [NODES];

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [NODE_W-1:0] mem_wdata;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [NODE_W-1:0] rd_ff;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [NODE_W-1:0] leaf_ff, leaf_in;
   logic              first_ff, first_in;
   logic              side_ff, side_in;
   logic [WINS_W-1:0] count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [PLAYER_W-1:0] champ_ff, champ_in;
   logic [SKILL_W-1:0]  champ_skill_ff, champ_skill_in;
   logic [WINS_W-1:0]   wins_ff, wins_in;

   logic [LOG_PLAYERS-1:0] who;
   logic [ADDR_W-1:0]      leaf_addr;
   logic [NODE_W-1:0]      left_node, right_node, winner, node_val;
   logic                   out_free;
   logic                   match;
   logic [WINS_W-1:0]      count_next;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_ff <= node_mem[rd_addr];
      end
   end

   // Player number wrapped to the tree size, and its leaf address.
   assign who       = LOG_PLAYERS'(req_chan.player);
   assign leaf_addr = {1'b1, who};

   // One match: the walked pair against the sibling just read.
   assign right_node = side_ff ? cur_ff : rd_ff;
   assign left_node  = side_ff ? rd_ff : cur_ff;
   assign winner     = (right_node > left_node) ? right_node : left_node;
   assign node_val   = first_ff ? cur_ff : winner;

   // Wins walk: compare an ancestor with the leaf pair, saturating the count.
   assign match      = (rd_ff == leaf_ff);
   assign count_next = (match && count_ff != WINS_MAX) ? count_ff + WINS_W'(1) : count_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      leaf_ff        <= leaf_in;
      first_ff       <= first_in;
      side_ff        <= side_in;
      count_ff       <= count_in;
      rsp_kind_ff    <= rsp_kind_in;
      champ_ff       <= champ_in;
      champ_skill_ff <= champ_skill_in;
      wins_ff        <= wins_in;
   end

   // Sequencer: next state, memory control and response loading.
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      cur_in         = cur_ff;
      leaf_in        = leaf_ff;
      first_in       = first_ff;
      side_in        = side_ff;
      count_in       = count_ff;
      mem_we         = 1'b0;
      mem_waddr      = pos_ff;
      mem_wdata      = node_val;
      rd_en          = 1'b0;
      rd_addr        = pos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in    = rsp_kind_ff;
      champ_in       = champ_ff;
      champ_skill_in = champ_skill_ff;
      wins_in        = wins_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.req_type)
                  REQ_SET: begin
                     cur_in   = {req_chan.skill, who};
                     pos_in   = leaf_addr;
                     first_in = 1'b1;
                     state_in = ST_SET;
                  end
                  REQ_CHAMP: begin
                     rd_en    = 1'b1;
                     rd_addr  = ROOT_ADDR;
                     state_in = ST_CHAMP;
                  end
                  REQ_WINS: begin
                     rd_en    = 1'b1;
                     rd_addr  = leaf_addr;
                     pos_in   = leaf_addr >> 1;
                     count_in = '0;
                     state_in = ST_WLEAF;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SET: begin
            // Write the current node and fetch the sibling for the next match.
            mem_we   = 1'b1;
            cur_in   = node_val;
            first_in = 1'b0;
            if (pos_ff == ROOT_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = pos_ff ^ ROOT_ADDR;
               side_in = pos_ff[0];
               pos_in  = pos_ff >> 1;
            end
         end
         ST_CHAMP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = RSP_CHAMP;
               champ_in       = PLAYER_W'(rd_ff[LOG_PLAYERS-1:0]);
               champ_skill_in = rd_ff[NODE_W-1 -: SKILL_W];
               wins_in        = '0;
               state_in       = ST_IDLE;
            end
         end
         ST_WLEAF: begin
            // Keep the leaf pair and fetch its parent.
            leaf_in  = rd_ff;
            rd_en    = 1'b1;
            rd_addr  = pos_ff;
            pos_in   = pos_ff >> 1;
            state_in = ST_WCMP;
         end
         ST_WCMP: begin
            // Stop at the first mismatch or after the root has been compared.
            if (!match || pos_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = RSP_WINS;
                  champ_in       = '0;
                  champ_skill_in = '0;
                  wins_in        = count_next;
                  state_in       = ST_IDLE;
               end
            end else begin
               count_in = count_next;
               rd_en    = 1'b1;
               rd_addr  = pos_ff;
               pos_in   = pos_ff >> 1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.resp_kind      = rsp_kind_ff;
   assign rsp_chan.champion       = champ_ff;
   assign rsp_chan.champion_skill = champ_skill_ff;
   assign rsp_chan.wins           = wins_ff;

`ifndef ASSERT_OFF
   // A new response only comes out of a finished query.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> ($past(state_ff) == ST_CHAMP || $past(state_ff) == ST_WCMP))
      else $error("response raised outside a query");

   // A wins answer carries zero champion fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.resp_kind == RSP_WINS)
         |-> (rsp_chan.champion == '0 && rsp_chan.champion_skill == '0))
      else $error("wins answer with nonzero champion fields");

   // The set walk never addresses the unused entry zero.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SET) |-> (pos_ff != '0))
      else $error("set walk reached address zero");

   // A set request never produces a response.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.req_type == REQ_SET)
         |=> !$rose(rsp_chan.valid))
      else $error("set request produced a response");
`endif

endmodule

FILE: bench/tournament_max_tree_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for tournament_max_tree: set, champion and wins requests
// against a behavioral copy of the tree. Depends on tmt_pkg, tmt_req_if, tmt_rsp_if.
module tournament_max_tree_test;
   import tmt_pkg::*;

   localparam int LOG_PLAYERS      = DEFAULT_LOG_PLAYERS;
   localparam int LEAVES           = 1 << LOG_PLAYERS;
   localparam int CLOCK_PERIOD     = 8;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int DRAIN_CYCLES     = LOG_PLAYERS + 8;
   localparam int RANDOM_PER_PHASE = 340;

   // Request code that the block must ignore.
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [SKILL_W-1:0]    SKILL_MAX  = '1;

   typedef struct packed {
      logic [SKILL_W-1:0]  skill;
      logic [PLAYER_W-1:0] player;
   } entrant_type;

   typedef struct {
      logic [REQ_TYPE_W-1:0] kind;
      logic [PLAYER_W-1:0]   player;
      logic [SKILL_W-1:0]    skill;
   } request_type;

   typedef struct {
      logic                kind;
      logic [PLAYER_W-1:0] champion;
      logic [SKILL_W-1:0]  champion_skill;
      logic [WINS_W-1:0]   wins;
   } answer_type;

   logic clock;
   logic reset;

   tmt_req_if req_if ();
   tmt_rsp_if rsp_if ();

   tournament_max_tree #(
      .LOG_PLAYERS(LOG_PLAYERS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Shadow copy of the bracket: entry 1 is the root, leaves follow at LEAVES.
   entrant_type bracket [1:2*LEAVES-1];
   request_type pending_requests [$];
   answer_type  answers_due [$];
   request_type in_flight;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          cycles = 0;
   bit          failed = 1'b0;

   // A pair beats another on larger skill; equal skills go to the larger player.
   function automatic bit outranks(entrant_type a, entrant_type b);
      if (a.skill != b.skill) return a.skill > b.skill;
      return a.player > b.player;
   endfunction

   // Apply one accepted request to the shadow bracket and queue its answer.
   task automatic play_request(input request_type r);
      int          pos;
      int          count;
      entrant_type leaf;
      answer_type  ans;
      pos = LEAVES + (r.player % LEAVES);
      ans = '{default: '0};
      case (r.kind)
         REQ_SET: begin
            bracket[pos] = '{skill: r.skill, player: PLAYER_W'(pos - LEAVES)};
            while (pos > 1) begin
               pos = pos >> 1;
               bracket[pos] = outranks(bracket[2*pos+1], bracket[2*pos]) ?
                              bracket[2*pos+1] : bracket[2*pos];
            end
         end
         REQ_CHAMP: begin
            ans.kind           = RSP_CHAMP;
            ans.champion       = bracket[1].player;
            ans.champion_skill = bracket[1].skill;
            answers_due.push_back(ans);
         end
         REQ_WINS: begin
            leaf  = bracket[pos];
            count = 0;
            while (pos > 1) begin
               pos = pos >> 1;
               if (bracket[pos] != leaf) break;
               count++;
            end
            ans.kind = RSP_WINS;
            ans.wins = (count > WINS_MAX) ? WINS_MAX : WINS_W'(count);
            answers_due.push_back(ans);
         end
         default: ;
      endcase
   endtask

   task automatic push_req(input logic [REQ_TYPE_W-1:0] kind,
                           input logic [PLAYER_W-1:0] player,
                           input logic [SKILL_W-1:0] skill);
      request_type r;
      r = '{kind: kind, player: player, skill: skill};
      pending_requests.push_back(r);
   endtask

   // Skills lean toward ties and the extremes so that tie-breaks happen often.
   function automatic logic [SKILL_W-1:0] pick_skill();
      case ($urandom_range(3))
         0, 1:    return $urandom;
         2:       return $urandom_range(3);
         default: return SKILL_MAX - $urandom_range(1);
      endcase
   endfunction

   // Random mix; many set requests are followed by a wins query on the same player.
   task automatic add_random(input int n);
      int                  i;
      int                  roll;
      logic [PLAYER_W-1:0] who;
      for (i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         who  = PLAYER_W'($urandom_range(LEAVES - 1));
         if (roll < 45) begin
            push_req(REQ_SET, who, pick_skill());
            if ($urandom_range(2) == 0) push_req(REQ_WINS, who, $urandom);
         end else if (roll < 70) begin
            push_req(REQ_CHAMP, PLAYER_W'($urandom), $urandom);
         end else if (roll < 95) begin
            push_req(REQ_WINS, who, $urandom);
         end else begin
            push_req(REQ_UNUSED, PLAYER_W'($urandom), $urandom);
         end
      end
   endtask

   // Hold off until every request is taken and every answer has come back.
   task automatic wait_quiet();
      while (pending_requests.size() != 0 || req_if.valid || answers_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [SKILL_W-1:0] want,
                              input logic [SKILL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // The cycle counter ends a run that hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Request driver: presents the next pending request, idling at random.
   always @(posedge clock) begin : request_driver
      request_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) play_request(in_flight);
         if (!req_if.valid || req_if.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt       = pending_requests.pop_front();
               in_flight = nxt;
               req_if.req_type <= nxt.kind;
               req_if.player   <= nxt.player;
               req_if.skill    <= nxt.skill;
               req_if.valid    <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: stalls at random and checks each answer against the oldest one due.
   always @(posedge clock) begin : answer_monitor
      answer_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (answers_due.size() == 0) begin
               $display({"%0t: unexpected response: expected none, ",
                         "actual kind %0d champion %0d skill %0h wins %0d"},
                        $time, rsp_if.resp_kind, rsp_if.champion, rsp_if.champion_skill,
                        rsp_if.wins);
               failed = 1'b1;
            end else begin
               want = answers_due.pop_front();
               check_field("resp_kind", SKILL_W'(want.kind), SKILL_W'(rsp_if.resp_kind));
               check_field("champion", SKILL_W'(want.champion), SKILL_W'(rsp_if.champion));
               check_field("champion_skill", want.champion_skill, rsp_if.champion_skill);
               check_field("wins", SKILL_W'(want.wins), SKILL_W'(rsp_if.wins));
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Stimulus: load every leaf, directed cases, then three random phases.
   initial begin : stimulus
      int p;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.req_type = REQ_SET;
      req_if.player   = '0;
      req_if.skill    = '0;
      rsp_if.ready    = 1'b0;
      for (p = 1; p < 2 * LEAVES; p++) bracket[p] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Phase one: slow receiver, mostly eager sender.
      send_idle_pct = 18;
      recv_idle_pct = 84;

      // Every leaf must be written before any query; all tied at zero skill.
      for (p = 0; p < LEAVES; p++) push_req(REQ_SET, PLAYER_W'(p), '0);

      // All ties: the highest player number takes every match.
      push_req(REQ_CHAMP, '0, '0);
      push_req(REQ_WINS, PLAYER_W'(LEAVES - 1), '0);
      push_req(REQ_WINS, PLAYER_W'(LEAVES - 2), SKILL_MAX);
      push_req(REQ_WINS, '0, '0);
      // Lowest player with the largest skill wins outright.
      push_req(REQ_SET, '0, SKILL_MAX);
      push_req(REQ_CHAMP, '1, '1);
      push_req(REQ_WINS, '0, '0);
      push_req(REQ_WINS, PLAYER_W'(1), '0);
      // Tie at the maximum skill goes to the larger player number.
      push_req(REQ_SET, PLAYER_W'(LEAVES - 1), SKILL_MAX);
      push_req(REQ_CHAMP, '0, '0);
      push_req(REQ_WINS, '0, '0);
      push_req(REQ_WINS, PLAYER_W'(LEAVES - 1), '0);
      push_req(REQ_SET, PLAYER_W'(LEAVES / 2), SKILL_MAX);
      push_req(REQ_WINS, PLAYER_W'(LEAVES / 2), '0);
      // Dethrone the champion and check the runner-up takes over.
      push_req(REQ_SET, PLAYER_W'(LEAVES - 1), '0);
      push_req(REQ_CHAMP, '0, '0);
      push_req(REQ_WINS, PLAYER_W'(LEAVES / 2), '0);
      // An unknown request type must change nothing and answer nothing.
      push_req(REQ_UNUSED, PLAYER_W'(LEAVES - 1), SKILL_MAX);
      push_req(REQ_CHAMP, '0, '0);
      push_req(REQ_SET, '0, '0);
      push_req(REQ_SET, PLAYER_W'(LEAVES / 2), 32'h7FFF_FFFF);
      push_req(REQ_CHAMP, '0, '0);
      push_req(REQ_WINS, PLAYER_W'(LEAVES / 2 - 1), '0);

      add_random(RANDOM_PER_PHASE);
      wait_quiet();

      // Phase two: slow sender, eager receiver.
      send_idle_pct = 84;
      recv_idle_pct = 18;
      add_random(RANDOM_PER_PHASE);
      wait_quiet();

      // Phase three: no idling on either side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(RANDOM_PER_PHASE);
      wait_quiet();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failed) begin
         $display("FAILURE");
      end else begin
         $display("SUCCESS");
      end
      $finish;
   end

endmodule
